// File: hw/rtl/tier_hysteresis_table_defines.svh
// Assertion macros for the tier table.
// THT_ASSERT is gated by reset; THT_ASSERT_ALWAYS is checked through reset.
`ifndef TIER_HYSTERESIS_TABLE_DEFINES_SVH
`define TIER_HYSTERESIS_TABLE_DEFINES_SVH
`ifndef SYNTHESIS
`define THT_ASSERT(lbl, prop) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) \
      else $error("tier table check failed");
`define THT_ASSERT_ALWAYS(lbl, prop) \
   lbl: assert property (@(posedge clock) prop) \
      else $error("tier table check failed");
`else
`define THT_ASSERT(lbl, prop)
`define THT_ASSERT_ALWAYS(lbl, prop)
`endif
`endif

// File: hw/rtl/tht_pkg.sv
package tht_pkg;

   typedef logic [1:0] tier_type;

   localparam tier_type TIER_COLD = 2'd0;
   localparam tier_type TIER_COOL = 2'd1;
   localparam tier_type TIER_WARM = 2'd2;
   localparam tier_type TIER_HOT  = 2'd3;

   localparam logic CMD_TICK   = 1'b0;
   localparam logic CMD_FORGET = 1'b1;

   localparam int LEVEL_W = 11;
   localparam int DWELL_W = 8;
   localparam int SLOT_W  = 6;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 11;

   localparam logic [DWELL_W-1:0] DWELL_MAX = 8'hFF;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_WARM_THRESHOLD    = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_COOL_THRESHOLD    = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_HYSTERESIS_MARGIN = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_RESCUE_FLOOR      = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_AUDIO_CEILING     = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_MIN_DWELL         = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_AUDIO_ENABLED     = 3'd6;

   // register reset values
   localparam logic [LEVEL_W-1:0] RST_WARM_THRESHOLD    = 11'd717;
   localparam logic [LEVEL_W-1:0] RST_COOL_THRESHOLD    = 11'd307;
   localparam logic [LEVEL_W-1:0] RST_HYSTERESIS_MARGIN = 11'd51;
   localparam logic [LEVEL_W-1:0] RST_RESCUE_FLOOR      = 11'd768;
   localparam logic [LEVEL_W-1:0] RST_AUDIO_CEILING     = 11'd205;
   localparam logic [DWELL_W-1:0] RST_MIN_DWELL         = 8'd3;
   localparam logic               RST_AUDIO_ENABLED     = 1'b1;

   // controller -> datapath
   typedef struct packed {
      logic load;    // capture item, start table read
      logic commit;  // write table entry, load result register
   } ctl_cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic out_free;  // result register can take a new item
   } ctl_sts_type;

endpackage

// File: hw/rtl/tht_ctrl.sv
`include "tier_hysteresis_table_defines.svh"

module tht_ctrl
   import tht_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  ctl_sts_type sts,
   output ctl_cmd_type cmd
);

   localparam logic ST_IDLE = 1'b0;
   localparam logic ST_EVAL = 1'b1;

   logic state_ff;
   logic state_in;

   assign req_stall  = (state_ff != ST_IDLE);
   assign cmd.load   = req_valid && (state_ff == ST_IDLE);
   assign cmd.commit = (state_ff == ST_EVAL) && sts.out_free;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (cmd.load) begin
               state_in = ST_EVAL;
            end
         end
         ST_EVAL: begin
            if (sts.out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   `THT_ASSERT_ALWAYS(a_reset_idle, reset |=> (state_ff == ST_IDLE))
   `THT_ASSERT(a_load_to_eval, cmd.load |=> (state_ff == ST_EVAL) && req_stall)
   `THT_ASSERT(a_hold_when_full, (state_ff == ST_EVAL) && !sts.out_free |=> (state_ff == ST_EVAL))
   `THT_ASSERT(a_commit_only_eval, cmd.commit |-> (state_ff == ST_EVAL) && !cmd.load)

endmodule

// File: hw/rtl/tht_dp.sv
module tht_dp
   import tht_pkg::*;
#(
   parameter int ENTRIES = 64
)
(
   input  logic                  clock,
   input  logic                  reset,
   input  ctl_cmd_type           cmd,
   output ctl_sts_type           sts,
   input  logic                  csr_write_en,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_write_data,
   input  logic                  req_command,
   input  logic [SLOT_W-1:0]     req_slot,
   input  logic [LEVEL_W-1:0]    req_decay_level,
   input  logic                  req_focused,
   input  logic                  req_net_active,
   input  logic                  req_flow_interactive,
   input  logic                  req_audio_playing,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic [SLOT_W-1:0]     rsp_out_slot,
   output tier_type              rsp_tier,
   output logic                  rsp_move_needed,
   output logic                  rsp_updated
);

   // only 2**SLOT_W slots are addressable
   localparam int DEPTH  = (ENTRIES < (1 << SLOT_W)) ? ENTRIES : (1 << SLOT_W);
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int WORD_W = $bits(tier_type) + DWELL_W;

   // configuration
   logic [LEVEL_W-1:0] warm_thr_ff, cool_thr_ff, margin_ff, floor_ff, ceiling_ff;
   logic [DWELL_W-1:0] min_dwell_ff;
   logic               audio_en_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         warm_thr_ff  <= RST_WARM_THRESHOLD;
         cool_thr_ff  <= RST_COOL_THRESHOLD;
         margin_ff    <= RST_HYSTERESIS_MARGIN;
         floor_ff     <= RST_RESCUE_FLOOR;
         ceiling_ff   <= RST_AUDIO_CEILING;
         min_dwell_ff <= RST_MIN_DWELL;
         audio_en_ff  <= RST_AUDIO_ENABLED;
      end else if (csr_write_en) begin
         unique case (csr_index)
            CSR_WARM_THRESHOLD:    warm_thr_ff  <= csr_write_data;
            CSR_COOL_THRESHOLD:    cool_thr_ff  <= csr_write_data;
            CSR_HYSTERESIS_MARGIN: margin_ff    <= csr_write_data;
            CSR_RESCUE_FLOOR:      floor_ff     <= csr_write_data;
            CSR_AUDIO_CEILING:     ceiling_ff   <= csr_write_data;
            CSR_MIN_DWELL:         min_dwell_ff <= csr_write_data[DWELL_W-1:0];
            CSR_AUDIO_ENABLED:     audio_en_ff  <= csr_write_data[0];
            default: begin
            end
         endcase
      end
   end

   // captured item
   logic               cmd_ff;
   logic [SLOT_W-1:0]  slot_ff;
   logic [LEVEL_W-1:0] level_ff;
   logic               focused_ff, net_ff, inter_ff, audio_ff;

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         cmd_ff     <= req_command;
         slot_ff    <= req_slot;
         level_ff   <= req_decay_level;
         focused_ff <= req_focused;
         net_ff     <= req_net_active;
         inter_ff   <= req_flow_interactive;
         audio_ff   <= req_audio_playing;
      end
   end

   // entry store: tier and dwell in memory, valid bits in flops
   logic [WORD_W-1:0] entry_mem_ff [DEPTH];
   logic [WORD_W-1:0] rd_data_ff;
   logic [DEPTH-1:0]  valid_ff;
   logic [DEPTH-1:0]  valid_in;

   logic [ADDR_W-1:0] idx;
   logic              in_range;
   logic              mem_we;
   logic [WORD_W-1:0] mem_wdata;

   assign idx      = slot_ff[ADDR_W-1:0];
   assign in_range = (32'(slot_ff) < ENTRIES);

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         rd_data_ff <= entry_mem_ff[req_slot[ADDR_W-1:0]];
      end
      if (mem_we) begin
         entry_mem_ff[idx] <= mem_wdata;
      end
   end

   // evaluation
   logic               cur_valid;
   tier_type           cur_tier;
   logic [DWELL_W-1:0] held;
   logic               rescued, active;
   logic [LEVEL_W-1:0] lvl_floor, lvl;
   tier_type           prop;
   logic [LEVEL_W:0]   up_bound, lvl_plus_margin;
   logic [LEVEL_W-1:0] up_base, dn_base;
   logic               past;
   tier_type           new_tier;
   logic [DWELL_W-1:0] new_dwell;
   logic               move;

   always_comb begin
      cur_valid = valid_ff[idx];
      cur_tier  = cur_valid ? rd_data_ff[WORD_W-1 -: 2] : TIER_COLD;
      held      = cur_valid ? rd_data_ff[DWELL_W-1:0] : '0;
      active    = focused_ff || net_ff;
      rescued   = net_ff && inter_ff;

      lvl_floor = (rescued && (level_ff < floor_ff)) ? floor_ff : level_ff;
      lvl = (!focused_ff && audio_en_ff && audio_ff && !rescued && (lvl_floor > ceiling_ff))
            ? ceiling_ff : lvl_floor;

      if (lvl >= warm_thr_ff) begin
         prop = TIER_WARM;
      end else if (lvl >= cool_thr_ff) begin
         prop = TIER_COOL;
      end else begin
         prop = TIER_COLD;
      end

      up_base         = (cur_tier == TIER_COLD) ? cool_thr_ff : warm_thr_ff;
      dn_base         = (cur_tier == TIER_WARM) ? warm_thr_ff : cool_thr_ff;
      up_bound        = {1'b0, up_base} + {1'b0, margin_ff};
      lvl_plus_margin = {1'b0, lvl} + {1'b0, margin_ff};
      if (prop == cur_tier) begin
         past = 1'b0;
      end else if (prop > cur_tier) begin
         past = ({1'b0, lvl} >= up_bound);
      end else begin
         past = (lvl_plus_margin < {1'b0, dn_base});
      end

      if (focused_ff) begin
         new_tier  = TIER_HOT;
         move      = !cur_valid || (cur_tier != TIER_HOT);
         new_dwell = '0;
      end else if (cur_valid) begin
         if (past && (held >= min_dwell_ff)) begin
            new_tier  = prop;
            move      = 1'b1;
            new_dwell = '0;
         end else begin
            new_tier  = cur_tier;
            move      = 1'b0;
            new_dwell = (held == DWELL_MAX) ? held : held + 1'b1;
         end
      end else begin
         new_tier  = prop;
         move      = 1'b1;
         new_dwell = '0;
      end
   end

   logic do_tick, do_forget;

   assign do_forget = cmd.commit && in_range && (cmd_ff == CMD_FORGET);
   assign do_tick   = cmd.commit && in_range && (cmd_ff == CMD_TICK) && active;
   assign mem_we    = do_tick;
   assign mem_wdata = {new_tier, new_dwell};

   always_comb begin
      valid_in = valid_ff;
      if (do_forget) begin
         valid_in[idx] = 1'b0;
      end else if (do_tick) begin
         valid_in[idx] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // result register
   logic     rsp_valid_ff, rsp_valid_in;
   logic [SLOT_W-1:0] rsp_slot_ff;
   tier_type rsp_tier_ff;
   logic     rsp_move_ff, rsp_upd_ff;

   assign sts.out_free = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.commit) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.commit) begin
         rsp_slot_ff <= slot_ff;
         rsp_tier_ff <= do_tick ? new_tier : TIER_COLD;
         rsp_move_ff <= do_tick && move;
         rsp_upd_ff  <= do_tick;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_out_slot    = rsp_slot_ff;
   assign rsp_tier        = rsp_tier_ff;
   assign rsp_move_needed = rsp_move_ff;
   assign rsp_updated     = rsp_upd_ff;

endmodule

// File: hw/rtl/tier_hysteresis_table.sv
// An item is captured when it is accepted; its result is loaded into the
// result register when it commits, and no new item is taken until then.
// The entry store is read when an item is accepted and written back when
// it commits, so the same slot may follow at once. A stalled result holds
// the controller in EVAL. Reset: synchronous; clears all entry valid bits
// and loads the register defaults. No clearing pass.
module tier_hysteresis_table
   import tht_pkg::*;
#(
   parameter int ENTRIES = 64
)
(
   input  logic                  clock,
   input  logic                  reset,
   // configuration writes
   input  logic                  csr_write_en,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_write_data,
   // item input
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic                  req_command,
   input  logic [SLOT_W-1:0]     req_slot,
   input  logic [LEVEL_W-1:0]    req_decay_level,
   input  logic                  req_focused,
   input  logic                  req_net_active,
   input  logic                  req_flow_interactive,
   input  logic                  req_audio_playing,
   // result output
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic [SLOT_W-1:0]     rsp_out_slot,
   output tier_type              rsp_tier,
   output logic                  rsp_move_needed,
   output logic                  rsp_updated
);

   // Controller: two states. IDLE takes an item and starts the table read;
   // EVAL waits for the result register to be free, then commits.
   ctl_cmd_type cmd;
   ctl_sts_type sts;

   tht_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .sts       (sts),
      .cmd       (cmd)
   );

   // Datapath: config registers, entry store (tier + dwell per slot, valid
   // bits in flops), level adjust, tier proposal, hysteresis check and the
   // result register. Slots at or past ENTRIES leave the store untouched.
   tht_dp #(
      .ENTRIES (ENTRIES)
   ) u_dp (
      .clock                (clock),
      .reset                (reset),
      .cmd                  (cmd),
      .sts                  (sts),
      .csr_write_en         (csr_write_en),
      .csr_index            (csr_index),
      .csr_write_data       (csr_write_data),
      .req_command          (req_command),
      .req_slot             (req_slot),
      .req_decay_level      (req_decay_level),
      .req_focused          (req_focused),
      .req_net_active       (req_net_active),
      .req_flow_interactive (req_flow_interactive),
      .req_audio_playing    (req_audio_playing),
      .rsp_valid            (rsp_valid),
      .rsp_stall            (rsp_stall),
      .rsp_out_slot         (rsp_out_slot),
      .rsp_tier             (rsp_tier),
      .rsp_move_needed      (rsp_move_needed),
      .rsp_updated          (rsp_updated)
   );

endmodule

// File: sim/tier_hysteresis_table_tb.sv
`timescale 1ns / 100ps

module tier_hysteresis_table_tb
   import tht_pkg::*;
();

   localparam int SLOTS       = 64;
   localparam int CYCLE_LIMIT = 200000;  // slowest legal run is far below this
   localparam int DRAIN_WAIT  = 8;       // extra wait before the final results check

   // one tick or forget item as it goes onto the request port
   typedef struct {
      logic               command;
      logic [SLOT_W-1:0]  slot;
      logic [LEVEL_W-1:0] level;
      logic               focused;
      logic               net;
      logic               interactive;
      logic               audio;
   } tick_item_type;

   // what the table should answer for one item
   typedef struct {
      int slot;
      int tier;
      int move;
      int updated;
   } tier_result_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  csr_write_en = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_write_data = '0;
   logic                  req_valid = 1'b0;
   logic                  req_stall;
   logic                  req_command = CMD_TICK;
   logic [SLOT_W-1:0]     req_slot = '0;
   logic [LEVEL_W-1:0]    req_decay_level = '0;
   logic                  req_focused = 1'b0;
   logic                  req_net_active = 1'b0;
   logic                  req_flow_interactive = 1'b0;
   logic                  req_audio_playing = 1'b0;
   logic                  rsp_valid;
   logic                  rsp_stall = 1'b0;
   logic [SLOT_W-1:0]     rsp_out_slot;
   tier_type              rsp_tier;
   logic                  rsp_move_needed;
   logic                  rsp_updated;

   tier_hysteresis_table #(.ENTRIES(SLOTS)) u_dut (
      .clock                (clock),
      .reset                (reset),
      .csr_write_en         (csr_write_en),
      .csr_index            (csr_index),
      .csr_write_data       (csr_write_data),
      .req_valid            (req_valid),
      .req_stall            (req_stall),
      .req_command          (req_command),
      .req_slot             (req_slot),
      .req_decay_level      (req_decay_level),
      .req_focused          (req_focused),
      .req_net_active       (req_net_active),
      .req_flow_interactive (req_flow_interactive),
      .req_audio_playing    (req_audio_playing),
      .rsp_valid            (rsp_valid),
      .rsp_stall            (rsp_stall),
      .rsp_out_slot         (rsp_out_slot),
      .rsp_tier             (rsp_tier),
      .rsp_move_needed      (rsp_move_needed),
      .rsp_updated          (rsp_updated)
   );

   always #2 clock = ~clock;

   // ---------------------------------------------------------------
   // Shadow of the table: register copies and per-slot entry state.
   // ---------------------------------------------------------------
   int       cfg_warm    = RST_WARM_THRESHOLD;
   int       cfg_cool    = RST_COOL_THRESHOLD;
   int       cfg_margin  = RST_HYSTERESIS_MARGIN;
   int       cfg_rescue  = RST_RESCUE_FLOOR;
   int       cfg_ceiling = RST_AUDIO_CEILING;
   int       cfg_dwell   = RST_MIN_DWELL;
   bit       cfg_audio   = RST_AUDIO_ENABLED;

   bit       known_entry [SLOTS];
   tier_type held_tier   [SLOTS];
   int       dwell_ticks [SLOTS];

   tick_item_type   pending_items[$];     // filled by the sequence, drained by the driver
   tier_result_type tier_results_due[$];  // oldest expected answer first
   tick_item_type   cur_item;
   tier_result_type due;

   int errors          = 0;
   int accepted_items  = 0;
   int results_checked = 0;
   int forget_count    = 0;
   int skipped_count   = 0;
   int move_count      = 0;
   int settings_used   = 1;
   int cycle_count     = 0;

   // Work out the answer for one accepted item and update the shadow state.
   task automatic predict_tier(input tick_item_type it);
      tier_result_type r;
      int           s;
      int           level;
      int           bound;
      bit           rescued;
      bit           crossed;
      tier_type     prop;
      tier_type     cur;
      s         = it.slot;
      level     = it.level;
      r.slot    = s;
      r.tier    = TIER_COLD;
      r.move    = 0;
      r.updated = 0;
      if (it.command == CMD_FORGET) begin
         known_entry[s] = 1'b0;
         held_tier[s]   = TIER_COLD;
         dwell_ticks[s] = 0;
         forget_count++;
      end else if (it.focused || it.net) begin
         rescued = it.net && it.interactive;
         if (rescued && level < cfg_rescue)
            level = cfg_rescue;
         // unfocused audio-only entries are held down to the ceiling
         if (!it.focused && cfg_audio && it.audio && !rescued && level > cfg_ceiling)
            level = cfg_ceiling;
         if (level >= cfg_warm)      prop = TIER_WARM;
         else if (level >= cfg_cool) prop = TIER_COOL;
         else                        prop = TIER_COLD;
         r.updated = 1;
         if (it.focused) begin
            r.tier = TIER_HOT;
            r.move = (!known_entry[s] || held_tier[s] != TIER_HOT);
            dwell_ticks[s] = 0;
         end else if (known_entry[s]) begin
            cur     = held_tier[s];
            crossed = 1'b0;
            if (prop > cur) begin
               bound   = (cur == TIER_COLD) ? cfg_cool : cfg_warm;
               crossed = (level >= bound + cfg_margin);
            end else if (prop < cur) begin
               bound   = (cur == TIER_WARM) ? cfg_warm : cfg_cool;
               crossed = (level + cfg_margin < bound);
            end
            if (crossed && dwell_ticks[s] >= cfg_dwell) begin
               r.tier = prop;
               r.move = 1;
               dwell_ticks[s] = 0;
            end else begin
               r.tier = cur;
               if (dwell_ticks[s] < DWELL_MAX)
                  dwell_ticks[s]++;
            end
         end else begin
            r.tier = prop;
            r.move = 1;
            dwell_ticks[s] = 0;
         end
         known_entry[s] = 1'b1;
         held_tier[s]   = tier_type'(r.tier);
      end else begin
         skipped_count++;
      end
      move_count += r.move;
      tier_results_due.insert(tier_results_due.size(), r);
   endtask

   // Idle rates: sender 13 / receiver 52, then swapped, then no idling.
   function automatic int idle_pct(input bit receiver, input int progress);
      if (progress < 675)
         return receiver ? 52 : 13;
      if (progress < 1350)
         return receiver ? 13 : 52;
      return 0;
   endfunction

   task automatic check_field(input string name, input int want, input int got);
      if (want != got) begin
         $error("%s mismatch: expected %0d, got %0d", name, want, got);
         errors++;
      end
   endtask

   // ---------------------------------------------------------------
   // Driver: presents queued items, holds them while stalled.
   // Prediction happens at the edge where the item is taken.
   // ---------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) begin
            predict_tier(cur_item);
            accepted_items++;
         end
         if (!req_valid || !req_stall) begin
            if (pending_items.size() > 0 &&
                $urandom_range(99) >= idle_pct(1'b0, accepted_items)) begin
               cur_item = pending_items.pop_front();
               req_valid            <= 1'b1;
               req_command          <= cur_item.command;
               req_slot             <= cur_item.slot;
               req_decay_level      <= cur_item.level;
               req_focused          <= cur_item.focused;
               req_net_active       <= cur_item.net;
               req_flow_interactive <= cur_item.interactive;
               req_audio_playing    <= cur_item.audio;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // ---------------------------------------------------------------
   // Monitor: checks each taken result against the oldest prediction
   // and stalls the result port at random.
   // ---------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (tier_results_due.size() == 0) begin
               $error("result for slot %0d with no item outstanding", rsp_out_slot);
               errors++;
            end else begin
               due = tier_results_due.pop_front();
               check_field("out_slot", due.slot, rsp_out_slot);
               check_field("tier", due.tier, rsp_tier);
               check_field("move_needed", due.move, rsp_move_needed);
               check_field("updated", due.updated, rsp_updated);
               results_checked++;
            end
         end
         rsp_stall <= ($urandom_range(99) < idle_pct(1'b1, results_checked));
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Timeout after %0d cycles", cycle_count);
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   // ---------------------------------------------------------------
   // Sequence helpers
   // ---------------------------------------------------------------
   task automatic add_item(input logic cmd, input int slot, input int level,
                           input bit foc, input bit net, input bit inter, input bit aud);
      tick_item_type it;
      it.command     = cmd;
      it.slot        = SLOT_W'(slot);
      it.level       = LEVEL_W'(level);
      it.focused     = foc;
      it.net         = net;
      it.interactive = inter;
      it.audio       = aud;
      pending_items.insert(pending_items.size(), it);
   endtask

   // Wait until every item is taken and every answer is back.
   task automatic wait_drained();
      do
         @(posedge clock);
      while (pending_items.size() > 0 || req_valid || tier_results_due.size() > 0);
   endtask

   // Write all seven registers, one per cycle, block idle.
   task automatic program_regs(input int warm, input int cool, input int margin,
                               input int rescue, input int ceiling, input int dwell,
                               input int audio);
      int vals[7];
      vals = '{warm, cool, margin, rescue, ceiling, dwell, audio};
      for (int i = 0; i < 7; i++) begin
         @(posedge clock);
         csr_write_en   <= 1'b1;
         csr_index      <= i[CSR_IDX_W-1:0];
         csr_write_data <= vals[i][CSR_DATA_W-1:0];
         case (i[CSR_IDX_W-1:0])
            CSR_WARM_THRESHOLD:    cfg_warm    = vals[i] & 'h7FF;
            CSR_COOL_THRESHOLD:    cfg_cool    = vals[i] & 'h7FF;
            CSR_HYSTERESIS_MARGIN: cfg_margin  = vals[i] & 'h7FF;
            CSR_RESCUE_FLOOR:      cfg_rescue  = vals[i] & 'h7FF;
            CSR_AUDIO_CEILING:     cfg_ceiling = vals[i] & 'h7FF;
            CSR_MIN_DWELL:         cfg_dwell   = vals[i] & 'hFF;
            CSR_AUDIO_ENABLED:     cfg_audio   = vals[i][0];
            default: ;
         endcase
      end
      @(posedge clock);
      csr_write_en <= 1'b0;
      settings_used++;
   endtask

   // Level picked near whatever edge matters under the current registers.
   function automatic int pick_level();
      int edges[8];
      int v;
      edges = '{cfg_cool, cfg_warm, cfg_cool + cfg_margin, cfg_warm + cfg_margin,
                cfg_cool - cfg_margin, cfg_warm - cfg_margin, cfg_rescue, cfg_ceiling};
      case ($urandom_range(99) / 20)
         0, 1, 2: begin
            v = edges[$urandom_range(7)] + int'($urandom_range(6)) - 3;
            if (v < 0)    v = 0;
            if (v > 2047) v = 2047;
         end
         3:       v = $urandom_range(1024);
         default: v = $urandom_range(2047);
      endcase
      return v;
   endfunction

   // Mostly ticks on a small group of slots so entries get revisited,
   // with some forgets, skips and focused items mixed in.
   task automatic gen_items(input int count, input int slot_span,
                            input int forget_pct, input int focus_pct);
      int  kind;
      int  slot;
      bit  foc;
      bit  net;
      for (int n = 0; n < count; n++) begin
         slot = ($urandom_range(99) < 80) ? $urandom_range(slot_span - 1)
                                          : $urandom_range(SLOTS - 1);
         kind = $urandom_range(99);
         foc  = 1'b0;
         net  = 1'b1;
         if (kind < 8) begin
            net = 1'b0;                       // skipped tick
         end else if (kind < 8 + focus_pct) begin
            foc = 1'b1;
            net = $urandom_range(1);
         end
         if ($urandom_range(99) < forget_pct)
            add_item(CMD_FORGET, slot, $urandom_range(2047), $urandom_range(1),
                     $urandom_range(1), $urandom_range(1), $urandom_range(1));
         else
            add_item(CMD_TICK, slot, pick_level(), foc, net,
                     $urandom_range(99) < 30, $urandom_range(1));
      end
   endtask

   // ---------------------------------------------------------------
   // Main sequence
   // ---------------------------------------------------------------
   initial begin
      for (int i = 0; i < SLOTS; i++) begin
         known_entry[i] = 1'b0;
         held_tier[i]   = TIER_COLD;
         dwell_ticks[i] = 0;
      end
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // Directed part on the reset register values.
      add_item(CMD_TICK, 0, 0, 1, 0, 0, 0);        // new entry, focused -> hot
      add_item(CMD_TICK, 0, 2047, 1, 1, 1, 1);     // already hot, no move
      add_item(CMD_TICK, 1, 1024, 0, 1, 0, 0);     // new entry takes proposed warm
      add_item(CMD_TICK, 1, 2047, 0, 0, 1, 1);     // neither focus nor net: skipped
      repeat (3) add_item(CMD_TICK, 1, 0, 0, 1, 0, 0);  // dwell still too short
      add_item(CMD_TICK, 1, 0, 0, 1, 0, 0);        // dwell reached: drop to cold
      add_item(CMD_TICK, 2, 0, 0, 1, 1, 0);        // interactive flow lifted to floor
      add_item(CMD_TICK, 3, 1000, 0, 1, 0, 1);     // audio-only capped at ceiling
      add_item(CMD_TICK, 4, 100, 0, 1, 1, 1);      // rescued audio is not capped
      add_item(CMD_TICK, 5, 2047, 1, 0, 0, 1);     // focused audio stays hot
      add_item(CMD_TICK, 5, 0, 0, 1, 0, 0);        // hot holds while dwell is short
      add_item(CMD_FORGET, 0, 0, 0, 0, 0, 0);      // free a hot slot
      add_item(CMD_TICK, 0, 500, 0, 1, 0, 0);      // slot comes back as new (cool)
      add_item(CMD_FORGET, 63, 2047, 1, 1, 1, 1);  // forget of an unused slot
      add_item(CMD_TICK, 63, 2047, 0, 1, 0, 0);
      add_item(CMD_TICK, 62, 306, 0, 1, 0, 0);     // just under cool: new cold
      repeat (3) add_item(CMD_TICK, 62, 357, 0, 1, 0, 0);  // one short of margin
      add_item(CMD_TICK, 62, 358, 0, 1, 0, 0);     // exactly boundary + margin
      add_item(CMD_TICK, 62, 256, 0, 1, 0, 0);     // not below cool - margin
      wait_drained();

      // Random part, one register setting per phase.
      program_regs(717, 307, 51, 768, 205, 3, 1);
      gen_items(400, 8, 5, 17);
      wait_drained();

      program_regs(1024, 0, 0, 1024, 0, 0, 0);      // zero margin, no dwell, no audio
      gen_items(250, 8, 5, 17);
      wait_drained();

      program_regs(200, 800, 1024, 0, 1024, 1, 1);  // thresholds inverted, huge margin
      gen_items(250, 8, 5, 17);
      wait_drained();

      // mostly one slot, hammered with no focus or forget so the dwell count saturates
      program_regs(600, 300, 10, 500, 400, 255, 1);
      gen_items(450, 1, 0, 0);
      wait_drained();

      program_regs(2047, 2047, 2047, 2047, 2047, 255, 1);
      gen_items(150, 16, 5, 17);
      wait_drained();

      program_regs(0, 0, 0, 0, 0, 0, 1);
      gen_items(150, 16, 5, 17);
      wait_drained();

      program_regs($urandom_range(1024), $urandom_range(1024), $urandom_range(100),
                   $urandom_range(1024), $urandom_range(1024), $urandom_range(6),
                   $urandom_range(1));
      gen_items(300, 8, 5, 17);
      wait_drained();

      repeat (DRAIN_WAIT) @(posedge clock);
      if (tier_results_due.size() != 0) begin
         $error("%0d results never arrived", tier_results_due.size());
         errors++;
      end

      $display("Ran %0d items over %0d register settings: %0d forgets, %0d skipped ticks,",
               accepted_items, settings_used, forget_count, skipped_count);
      $display("%0d results checked, %0d of them asking for a tier move",
               results_checked, move_count);
      if (errors == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule

// File: tier_hysteresis_table.f
+incdir+hw/rtl
hw/rtl/tht_pkg.sv
hw/rtl/tht_ctrl.sv
hw/rtl/tht_dp.sv
hw/rtl/tier_hysteresis_table.sv
sim/tier_hysteresis_table_tb.sv
